[rtl/core/dss_pkg.sv]
// ----------------------------------------------------------------------------
// Delimiter stream splitter package
// Shared widths, codes and word types: the input word that passes from the
// front queue to the splitting engine, and the engine's result word.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

  localparam int DATA_W      = 8;
  localparam int DELIM_W     = 64;
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int USER_W      = 2;
  localparam int QUEUE_DEPTH = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b1;

  // Reset values of the configuration registers (a single comma).
  localparam logic [DELIM_W-1:0] DELIM_BYTES_RST  = 64'd44;
  localparam logic [LEN_W-1:0]   DELIM_LENGTH_RST = 4'd1;

  // Result kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  // One input word as it waits in the front queue.
  typedef struct packed {
    logic              last;
    logic [DATA_W-1:0] data;
  } item_t;

  // One result word.
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] value;
    logic              last_in_run;
    logic              string_end;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/dss_queue.sv]
// ----------------------------------------------------------------------------
// Delimiter stream splitter front queue
// Accepts input words and holds them in a short register queue so the input
// side keeps flowing while the engine is busy or the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire dss_pkg::item_t  in_item_i,
  output logic                 out_valid_o,
  output dss_pkg::item_t       out_item_o,
  input  wire logic            out_pop_i
);

  localparam int PTR_W = $clog2(dss_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(dss_pkg::QUEUE_DEPTH + 1);

  dss_pkg::item_t   mem_q [dss_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CNT_W'(dss_pkg::QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_pop_i && out_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(dss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(dss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dss_engine.sv]
// ----------------------------------------------------------------------------
// Delimiter stream splitter engine
// Holds the pending byte window, decides one result per cycle against the
// delimiter while the output register is free, and drives that register.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_engine #(
  parameter int MAX_DELIM = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               q_valid_i,
  input  wire dss_pkg::item_t                     q_item_i,
  output logic                                    q_pop_o,
  input  wire logic [dss_pkg::DELIM_W-1:0]        delim_i,
  input  wire logic [$clog2(MAX_DELIM+1)-1:0]     dlen_i,
  output logic                                    res_valid_o,
  output dss_pkg::res_t                           res_o,
  input  wire logic                               res_ready_i
);

  localparam int CNT_W = $clog2(MAX_DELIM + 1);
  localparam int DW    = dss_pkg::DATA_W;

  logic [DW-1:0]    win_q [MAX_DELIM];
  logic [DW-1:0]    win_d [MAX_DELIM];
  logic [DW-1:0]    win_c [MAX_DELIM];
  logic [DW-1:0]    win_s [MAX_DELIM];
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_c, cnt_n, n_c, drop_c;
  logic             busy_q, busy_d;
  logic             last_q, last_d, last_c;
  logic             seg_open_q, seg_open_d;
  logic             res_valid_q, res_valid_d;
  dss_pkg::res_t    res_q, res_c;
  logic             active, loop_c, close_c, match_c, cont_c, tail_close, final_c;
  logic             emit, out_free, fire;

  always_comb begin
    // Working view: the held window, or the held window with the queue head
    // appended when a new byte is being taken this cycle.
    last_c = busy_q ? last_q : q_item_i.last;
    cnt_c  = cnt_q;
    if (!busy_q && cnt_q < CNT_W'(MAX_DELIM)) begin
      cnt_c = cnt_q + 1'b1;
    end
    for (int i = 0; i < MAX_DELIM; i++) begin
      win_c[i] = win_q[i];
      if (!busy_q && CNT_W'(i) == cnt_q) begin
        win_c[i] = q_item_i.data;
      end
    end

    active  = busy_q || q_valid_i;
    loop_c  = (cnt_c != '0) && ((cnt_c >= dlen_i) || last_c);
    close_c = !loop_c && last_c && seg_open_q;
    n_c     = (cnt_c < dlen_i) ? cnt_c : dlen_i;

    match_c = 1'b1;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if (CNT_W'(i) < n_c && win_c[i] != delim_i[DW*i +: DW]) begin
        match_c = 1'b0;
      end
    end

    drop_c = '0;
    if (loop_c) begin
      drop_c = match_c ? n_c : CNT_W'(1);
    end
    cnt_n = cnt_c - drop_c;

    for (int i = 0; i < MAX_DELIM; i++) begin
      win_s[i] = win_c[i];
      if (i + int'(drop_c) < MAX_DELIM) begin
        win_s[i] = win_c[i + int'(drop_c)];
      end
    end

    // Look one decision ahead so the run and string flags land on the
    // final result of this byte.
    cont_c     = (cnt_n != '0) && ((cnt_n >= dlen_i) || last_c);
    tail_close = !cont_c && last_c && !match_c;
    final_c    = loop_c ? (!cont_c && !tail_close) : 1'b1;

    if (loop_c) begin
      res_c.kind  = match_c ? dss_pkg::KIND_MARK : dss_pkg::KIND_BYTE;
      res_c.value = match_c ? '0 : win_c[0];
    end else begin
      res_c.kind  = dss_pkg::KIND_MARK;
      res_c.value = '0;
    end
    res_c.last_in_run = final_c;
    res_c.string_end  = final_c && last_c;

    emit     = active && (loop_c || close_c);
    out_free = !res_valid_q || res_ready_i;
    fire     = emit && out_free;
    q_pop_o  = !busy_q && q_valid_i;

    busy_d     = busy_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    seg_open_d = seg_open_q;
    win_d      = win_q;
    if (active) begin
      cnt_d  = cnt_c;
      last_d = last_c;
      win_d  = win_c;
      busy_d = emit;
      if (fire) begin
        if (loop_c) begin
          cnt_d      = cnt_n;
          win_d      = win_s;
          seg_open_d = !match_c;
          busy_d     = !final_c;
        end else begin
          seg_open_d = 1'b0;
          busy_d     = 1'b0;
        end
      end
    end

    res_valid_d = res_valid_q;
    if (fire) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      seg_open_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      seg_open_q  <= seg_open_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (fire) begin
      res_q <= res_c;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The window never holds more than its depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_DELIM))
    else $error("pending count exceeds window depth");

  // After the final result of a string the engine is empty and closed.
  a_string_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_c.string_end) |=> (cnt_q == '0 && !seg_open_q && !busy_q))
    else $error("state not cleared after end of string");

  // A string end is always also the end of the run.
  a_end_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.string_end) |-> res_q.last_in_run)
    else $error("string end without run end");

  // Markers carry a zero value.
  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.kind == dss_pkg::KIND_MARK) |-> (res_q.value == '0))
    else $error("marker with nonzero value");

  // A new byte is only taken when no earlier byte is still being resolved.
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !busy_q)
    else $error("queue popped while engine busy");

endmodule

`default_nettype wire

[rtl/core/delimiter_stream_splitter_unit.sv]
// ----------------------------------------------------------------------------
// Delimiter stream splitter
// Splits a byte string on a configurable delimiter of 1 to MAX_DELIM bytes,
// emitting segment bytes and end-of-segment markers.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents (lowest bit first)
//   s_*      in         tdata: data_byte[7:0]; tlast: is_last
//   m_*      out        tdata: value[7:0]; tuser: kind, string_end;
//                       tlast: last_in_run
//   cfg_*    in         index 0: delimiter bytes (64 bits), 1: delimiter length
//
// Throughput: a word that causes zero or one result words keeps a rate of one
// word per clock while the output register is free; a word that causes more
// holds the queue until all its results are out. The single output register
// takes one result word per cycle from the window compare while it is free.
// Reset clears the queue, the window count, the open-segment flag and the
// output valid; the configuration returns to a one-byte comma delimiter.
// Stalls: a two-word queue sits between the input and the engine, and the
// output register sits between the engine and the output, so either side can
// stall without blocking the other until the queue fills. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_stream_splitter_unit #(
  parameter int MAX_DELIM = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input stream.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [dss_pkg::DATA_W-1:0]        s_tdata,   // data_byte[7:0]
  input  wire logic                              s_tlast,   // is_last
  // Output stream.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [dss_pkg::DATA_W-1:0]             m_tdata,   // value[7:0]
  output logic [dss_pkg::USER_W-1:0]             m_tuser,   // [0] kind, [1] string_end
  output logic                                   m_tlast,   // last_in_run
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dss_pkg::DELIM_W-1:0]       cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_DELIM + 1);
  localparam int LW    = dss_pkg::LEN_W;

  logic [dss_pkg::DELIM_W-1:0] delim_q;
  logic [LW-1:0]               len_q;
  logic [LW-1:0]               len_eff;
  logic [CNT_W-1:0]            dlen;
  dss_pkg::item_t              in_item, q_item;
  logic                        q_valid, q_pop;
  dss_pkg::res_t               res;

  // Configuration registers. Only the listed indexes are stored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= dss_pkg::DELIM_BYTES_RST;
      len_q   <= dss_pkg::DELIM_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dss_pkg::REG_DELIM_BYTES:  delim_q <= cfg_data_i;
        dss_pkg::REG_DELIM_LENGTH: len_q   <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one byte, and anything above the window depth is
  // clamped to the depth.
  always_comb begin
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = LW'(1);
    end else if (len_q > LW'(MAX_DELIM)) begin
      len_eff = LW'(MAX_DELIM);
    end
  end
  assign dlen = CNT_W'(len_eff);

  assign in_item.data = s_tdata;
  assign in_item.last = s_tlast;

  // Front: accepts words into the queue.
  dss_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_item_i   (in_item),
    .out_valid_o (q_valid),
    .out_item_o  (q_item),
    .out_pop_i   (q_pop)
  );

  // Back: resolves the window and drives the output register.
  dss_engine #(
    .MAX_DELIM (MAX_DELIM)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .delim_i     (delim_q),
    .dlen_i      (dlen),
    .res_valid_o (m_tvalid),
    .res_o       (res),
    .res_ready_i (m_tready)
  );

  assign m_tdata    = res.value;
  assign m_tuser[0] = res.kind;
  assign m_tuser[1] = res.string_end;
  assign m_tlast    = res.last_in_run;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delimiter stream splitter testbench
// Feeds byte strings into the splitter under a series of delimiter settings
// and checks every result word against a behavioral predictor of the window
// match or typed-in results. A directed table runs first, then random strings.
// ----------------------------------------------------------------------------

module testbench;

  localparam int MAX_DELIM     = 8;
  localparam int MAX_RUN       = MAX_DELIM + 2;
  // Enough cycles for a word still in the front queue to clear the engine.
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_WORDS   = 28;

  // One row of the directed table: either a register write or an input word.
  // Rows with n_known above zero carry their expected results typed in.
  typedef struct packed {
    logic                          is_cfg;
    logic [dss_pkg::CFG_IDX_W-1:0] idx;
    logic [dss_pkg::DELIM_W-1:0]   val;
    logic [dss_pkg::DATA_W-1:0]    b;
    logic                          lst;
    logic [1:0]                    n_known;
    dss_pkg::res_t [1:0]           known;
  } stim_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [dss_pkg::DATA_W-1:0]    s_tdata;
  logic                          s_tlast;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [dss_pkg::DATA_W-1:0]    m_tdata;
  logic [dss_pkg::USER_W-1:0]    m_tuser;
  logic                          m_tlast;
  logic                          cfg_we_i;
  logic [dss_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [dss_pkg::DELIM_W-1:0]   cfg_data_i;

  delimiter_stream_splitter_unit #(
    .MAX_DELIM(MAX_DELIM)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),     // data_byte[7:0]
    .s_tlast   (s_tlast),     // is_last
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),     // value[7:0]
    .m_tuser   (m_tuser),     // [0] kind, [1] string_end
    .m_tlast   (m_tlast),     // last_in_run
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predictor state: our own copy of the delimiter settings, the window of
  // held bytes and the open-segment flag.
  logic [dss_pkg::DELIM_W-1:0] delim_cfg;
  logic [dss_pkg::LEN_W-1:0]   dlen_cfg;
  logic [dss_pkg::DATA_W-1:0]  held_bytes [0:MAX_DELIM-1];
  int                          held_count;
  bit                          seg_open;

  // Result words that the splitter still owes us, oldest first.
  dss_pkg::res_t               expected_words [$];
  stim_row_t                   plan_q [$];

  int                          errors;
  int                          cycle_count;
  bit                          calm;          // no idling on either side while set
  dss_pkg::res_t               mon_got;
  dss_pkg::res_t               mon_want;
  int                          p;
  int                          i;
  logic [dss_pkg::DELIM_W-1:0] dv;
  logic [dss_pkg::LEN_W-1:0]   lv;

  function automatic dss_pkg::res_t word_of(logic kind, logic [dss_pkg::DATA_W-1:0] value,
                                            logic lir, logic se);
    dss_pkg::res_t w;
    w.kind        = kind;
    w.value       = value;
    w.last_in_run = lir;
    w.string_end  = se;
    return w;
  endfunction

  // The clock runs free from time zero with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A cycle counter guards against a hang anywhere in the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // The receiver stalls about seven percent of the time, except while the calm
  // stretch is on.
  always @(posedge clk_i) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 7);
  end

  // Result checker. A word is taken at an edge where valid and ready are both
  // high; the values read here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      mon_got = word_of(m_tuser[0], m_tdata, m_tlast, m_tuser[1]);
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result word: kind %0d value %02h last_in_run %0d string_end %0d",
                   mon_got.kind, mon_got.value, mon_got.last_in_run, mon_got.string_end);
      end else begin
        mon_want = expected_words.pop_front();
        if (mon_got !== mon_want) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("result mismatch: expected kind %0d value %02h last_in_run %0d %s %0d, %s",
                     mon_want.kind, mon_want.value, mon_want.last_in_run, "string_end",
                     mon_want.string_end,
                     $sformatf("got kind %0d value %02h last_in_run %0d string_end %0d",
                               mon_got.kind, mon_got.value, mon_got.last_in_run,
                               mon_got.string_end));
        end
      end
    end
  end

  // A length of zero acts as one, and anything above the window size is
  // clipped to the window size.
  function automatic int eff_len();
    if (dlen_cfg == '0) return 1;
    if (int'(dlen_cfg) > MAX_DELIM) return MAX_DELIM;
    return int'(dlen_cfg);
  endfunction

  function automatic logic [dss_pkg::DATA_W-1:0] pick_small();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h5A;
      default: return 8'hA5;
    endcase
  endfunction

  function automatic void drop_held(int n);
    int j;
    if (n >= held_count) begin
      held_count = 0;
    end else begin
      for (j = 0; j + n < held_count; j++)
        held_bytes[j] = held_bytes[j + n];
      held_count -= n;
    end
  endfunction

  // Splitter predictor. The new byte joins the window, then every decision
  // that can be made is made: a full delimiter match at the front gives a
  // marker and drops the match, anything else releases the oldest byte. At
  // the end of a string a shorter tail that equals a delimiter prefix counts
  // as a match, and an open segment gets a closing marker.
  task automatic predict_split(input logic [dss_pkg::DATA_W-1:0] b, input logic lst,
                               input bit keep);
    dss_pkg::res_t run_words [0:MAX_RUN-1];
    int            n;
    int            d;
    int            take;
    int            j;
    bit            hit;
    n = 0;
    d = eff_len();
    if (held_count < MAX_DELIM) begin
      held_bytes[held_count] = b;
      held_count++;
    end
    while (held_count > 0 && (held_count >= d || lst)) begin
      take = (held_count < d) ? held_count : d;
      hit  = 1'b1;
      for (j = 0; j < take; j++)
        if (held_bytes[j] != delim_cfg[j*8 +: 8]) hit = 1'b0;
      if (hit) begin
        run_words[n] = word_of(dss_pkg::KIND_MARK, '0, 1'b0, 1'b0);
        seg_open = 1'b0;
        drop_held(take);
      end else begin
        run_words[n] = word_of(dss_pkg::KIND_BYTE, held_bytes[0], 1'b0, 1'b0);
        seg_open = 1'b1;
        drop_held(1);
      end
      n++;
    end
    if (lst) begin
      if (seg_open) begin
        run_words[n] = word_of(dss_pkg::KIND_MARK, '0, 1'b0, 1'b0);
        n++;
        seg_open = 1'b0;
      end
      held_count = 0;
    end
    if (n > 0) begin
      run_words[n-1].last_in_run = 1'b1;
      run_words[n-1].string_end  = lst;
    end
    if (keep)
      for (j = 0; j < n; j++) expected_words.push_back(run_words[j]);
  endtask

  // Stops sending, waits until every owed result word has come, then lets the
  // engine settle, since a word with no result may still be in flight.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dss_pkg::DELIM_W-1:0] val);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == dss_pkg::REG_DELIM_BYTES) delim_cfg = val;
    else                                 dlen_cfg  = val[dss_pkg::LEN_W-1:0];
  endtask

  // Sends one input word. The sender idles now and then with valid low; once
  // valid is up it stays up until the word is taken. Rows with typed-in
  // results push those instead of the predictor's, but the predictor still
  // steps so that its state follows the block.
  task automatic send_word(input logic [dss_pkg::DATA_W-1:0] b, input logic lst,
                           input int n_known, input dss_pkg::res_t k0,
                           input dss_pkg::res_t k1);
    if (!calm && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while (!calm && $urandom_range(0, 99) < 7);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_split(b, lst, n_known == 0);
    if (n_known > 0) expected_words.push_back(k0);
    if (n_known > 1) expected_words.push_back(k1);
  endtask

  task automatic plan_row(input logic is_cfg, input logic [dss_pkg::CFG_IDX_W-1:0] idx,
                          input logic [dss_pkg::DELIM_W-1:0] val,
                          input logic [dss_pkg::DATA_W-1:0] b, input logic lst,
                          input int n_known, input dss_pkg::res_t k0,
                          input dss_pkg::res_t k1);
    stim_row_t r;
    r.is_cfg   = is_cfg;
    r.idx      = idx;
    r.val      = val;
    r.b        = b;
    r.lst      = lst;
    r.n_known  = n_known[1:0];
    r.known[0] = k0;
    r.known[1] = k1;
    plan_q.push_back(r);
  endtask

  // Random strings built from whole delimiters, delimiter prefixes (which may
  // break off a match), single delimiter bytes and free bytes. Every string
  // ends with its last flag. With pause_mid set, the sender holds off after
  // the second string until the block has delivered everything.
  task automatic run_phase(input int n_words, input bit pause_mid);
    logic [dss_pkg::DATA_W-1:0] str_q [$];
    int sent;
    int strings;
    int want_len;
    int r;
    int e;
    int j;
    int cut;
    sent    = 0;
    strings = 0;
    while (sent < n_words) begin
      str_q.delete();
      e        = eff_len();
      want_len = $urandom_range(1, 16);
      while (str_q.size() < want_len) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          for (j = 0; j < e; j++) str_q.push_back(delim_cfg[j*8 +: 8]);
        end else if (r < 35) begin
          cut = $urandom_range(1, e);
          for (j = 0; j < cut; j++) str_q.push_back(delim_cfg[j*8 +: 8]);
        end else if (r < 55) begin
          str_q.push_back(delim_cfg[$urandom_range(0, e - 1)*8 +: 8]);
        end else if (r < 65) begin
          str_q.push_back(pick_small());
        end else begin
          str_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      for (j = 0; j < str_q.size(); j++)
        send_word(str_q[j], j == str_q.size() - 1, 0, '0, '0);
      sent += str_q.size();
      strings++;
      if (pause_mid && strings == 2) quiesce();
    end
  endtask

  initial begin
    // Every input is known from time zero; reset is held low before the run starts.
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    m_tready    <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= dss_pkg::REG_DELIM_BYTES;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    errors      = 0;
    cycle_count = 0;
    calm        = 1'b0;
    delim_cfg   = dss_pkg::DELIM_BYTES_RST;
    dlen_cfg    = dss_pkg::DELIM_LENGTH_RST;
    held_count  = 0;
    seg_open    = 1'b0;
    for (i = 0; i < MAX_DELIM; i++) held_bytes[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. The first four words run on the reset delimiter, a
    // single comma, and their results can be read off directly: a leading
    // comma gives an empty segment, the extremes of the byte pass through,
    // the end of a string closes its segment, and a final comma gives no
    // trailing empty segment.
    plan_row(0, '0, '0, 8'h2C, 0, 1, word_of(dss_pkg::KIND_MARK, 8'h00, 1, 0), '0);
    plan_row(0, '0, '0, 8'h00, 0, 1, word_of(dss_pkg::KIND_BYTE, 8'h00, 1, 0), '0);
    plan_row(0, '0, '0, 8'hFF, 1, 2, word_of(dss_pkg::KIND_BYTE, 8'hFF, 0, 0),
             word_of(dss_pkg::KIND_MARK, 8'h00, 1, 1));
    plan_row(0, '0, '0, 8'h2C, 1, 1, word_of(dss_pkg::KIND_MARK, 8'h00, 1, 1), '0);
    // Three-byte delimiter "abc": a byte before a match, then a tail that is
    // only a prefix of the delimiter at the end of a string.
    plan_row(1, dss_pkg::REG_DELIM_BYTES, 64'h0000_0000_0063_6261, '0, 0, 0, '0, '0);
    plan_row(1, dss_pkg::REG_DELIM_LENGTH, 64'd3, '0, 0, 0, '0, '0);
    plan_row(0, '0, '0, "x", 0, 0, '0, '0);
    plan_row(0, '0, '0, "a", 0, 0, '0, '0);
    plan_row(0, '0, '0, "b", 0, 0, '0, '0);
    plan_row(0, '0, '0, "c", 1, 0, '0, '0);
    plan_row(0, '0, '0, "z", 0, 0, '0, '0);
    plan_row(0, '0, '0, "a", 0, 0, '0, '0);
    plan_row(0, '0, '0, "b", 1, 0, '0, '0);
    // Leave two bytes held, then shrink the delimiter to one byte: the next
    // word resolves the whole window at once.
    plan_row(0, '0, '0, "q", 0, 0, '0, '0);
    plan_row(0, '0, '0, "a", 0, 0, '0, '0);
    plan_row(0, '0, '0, "b", 0, 0, '0, '0);
    plan_row(1, dss_pkg::REG_DELIM_LENGTH, 64'd1, '0, 0, 0, '0, '0);
    plan_row(0, '0, '0, "c", 1, 0, '0, '0);
    // A length of zero acts as one; back-to-back delimiters give empty
    // segments.
    plan_row(1, dss_pkg::REG_DELIM_LENGTH, 64'd0, '0, 0, 0, '0, '0);
    plan_row(0, '0, '0, "a", 0, 0, '0, '0);
    plan_row(0, '0, '0, "a", 1, 0, '0, '0);
    // All-ones delimiter with an oversized length, clipped to eight bytes.
    plan_row(1, dss_pkg::REG_DELIM_BYTES, {dss_pkg::DELIM_W{1'b1}}, '0, 0, 0, '0, '0);
    plan_row(1, dss_pkg::REG_DELIM_LENGTH, 64'd15, '0, 0, 0, '0, '0);
    for (i = 0; i < MAX_DELIM; i++)
      plan_row(0, '0, '0, 8'hFF, i == MAX_DELIM - 1, 0, '0, '0);

    for (i = 0; i < plan_q.size(); i++) begin
      if (plan_q[i].is_cfg)
        write_reg(plan_q[i].idx, plan_q[i].val);
      else
        send_word(plan_q[i].b, plan_q[i].lst, int'(plan_q[i].n_known),
                  plan_q[i].known[0], plan_q[i].known[1]);
    end

    // Random phases, each under its own delimiter. The first few pin the
    // extremes of both registers; phase two holds the sender off once until
    // the block has drained, and phases four and five run with no idling.
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin dv = {dss_pkg::DELIM_W{1'b1}}; lv = 4'd8;  end
        1: begin dv = '0;                       lv = 4'd1;  end
        2: begin dv = {$urandom, $urandom};     lv = 4'd0;  end
        3: begin
          for (i = 0; i < MAX_DELIM; i++) dv[i*8 +: 8] = pick_small();
          lv = 4'd15;
        end
        default: begin
          if ($urandom_range(0, 1) == 0)
            for (i = 0; i < MAX_DELIM; i++) dv[i*8 +: 8] = pick_small();
          else
            dv = {$urandom, $urandom};
          lv = 4'($urandom_range(0, 15));
        end
      endcase
      write_reg(dss_pkg::REG_DELIM_BYTES, dv);
      write_reg(dss_pkg::REG_DELIM_LENGTH,
                {{(dss_pkg::DELIM_W-dss_pkg::LEN_W){1'b0}}, lv});
      calm = (p == 4 || p == 5);
      run_phase(PHASE_WORDS, p == 2);
    end
    calm = 1'b0;

    // Drain what is owed, give the block time to show any stray words, then
    // report.
    quiesce();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/dss_pkg.sv
rtl/core/dss_queue.sv
rtl/core/dss_engine.sv
rtl/core/delimiter_stream_splitter_unit.sv
tb/sv/testbench.sv
